// ===== hdl/hsfd_pkg.sv =====
// Shared constants, types, CRC-8 step and divide by 65535 for the decoder.
package hsfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int POS_W   = 3;
    localparam int TEMP_W  = 15;
    localparam int HUMID_W = 14;
    localparam int PROD_W  = 31;
    localparam int SUM_W   = 32;
    localparam int QUOT_W  = 15;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [POS_W-1:0] POS_T_MSB = 3'd0;
    localparam logic [POS_W-1:0] POS_T_LSB = 3'd1;
    localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_H_MSB = 3'd3;
    localparam logic [POS_W-1:0] POS_H_LSB = 3'd4;
    localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

    localparam logic [14:0] T_SPAN  = 15'd17500;
    localparam logic [14:0] RH_SPAN = 15'd12500;
    localparam logic [QUOT_W-1:0] T_BASE  = 15'd4500;
    localparam logic [QUOT_W-1:0] RH_BASE = 15'd600;
    localparam logic [QUOT_W-1:0] RH_MAX  = 15'd10000;

    typedef struct packed {
        logic [WORD_W-1:0] temp_ticks;
        logic [WORD_W-1:0] humid_ticks;
        logic              crc_fail;
    } t_frame;

    function automatic logic [BYTE_W-1:0] f_crc8(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 32768 * 65535 (15-bit quotient)
    function automatic logic [QUOT_W-1:0] f_div_ffff(input logic [PROD_W-1:0] x);
        logic [SUM_W-1:0] s;
        s = SUM_W'(x) + SUM_W'(x >> WORD_W) + SUM_W'(1);
        return s[WORD_W +: QUOT_W];
    endfunction

endpackage

// ===== hdl/hsfd_byte_if.sv =====
// Byte channel: valid/ready handshake with one frame byte per transfer.
interface hsfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

// ===== hdl/hsfd_result_if.sv =====
// Result channel: valid/ready handshake with one decoded reading per transfer.
interface hsfd_result_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temp_centi;
    logic [13:0]        humid_centi;
    logic               crc_ok;

    modport source (output valid, output temp_centi, output humid_centi, output crc_ok,
                    input ready);
    modport sink (input valid, input temp_centi, input humid_centi, input crc_ok,
                  output ready);
endinterface

// ===== hdl/hsfd_frame.sv =====
// Frame tracker: byte position, running CRC-8 and word assembly.
module hsfd_frame (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [hsfd_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_first_byte,
    output logic                          o_done,
    output hsfd_pkg::t_frame              o_frame
);
    import hsfd_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos, pos;
    logic [BYTE_W-1:0] r_crc, n_crc, crc_base, crc_step;
    logic [WORD_W-1:0] r_temp, n_temp, r_humid, n_humid;
    logic              r_fail, n_fail, fail_base;

    always_comb begin
        pos       = (i_first_byte || r_pos > POS_H_CRC) ? POS_T_MSB : r_pos;
        crc_base  = (pos == POS_T_MSB) ? CRC_INIT : r_crc;
        fail_base = (pos == POS_T_MSB) ? 1'b0 : r_fail;
        crc_step  = f_crc8(crc_base, i_data_byte);
        n_crc     = crc_step;
        n_fail    = fail_base;
        n_temp    = r_temp;
        n_humid   = r_humid;
        case (pos)
            POS_T_MSB: n_temp  = {i_data_byte, r_temp[BYTE_W-1:0]};
            POS_T_LSB: n_temp  = {r_temp[WORD_W-1:BYTE_W], i_data_byte};
            POS_H_MSB: n_humid = {i_data_byte, r_humid[BYTE_W-1:0]};
            POS_H_LSB: n_humid = {r_humid[WORD_W-1:BYTE_W], i_data_byte};
            POS_T_CRC, POS_H_CRC: begin
                n_crc = CRC_INIT;
                if (i_data_byte != crc_base) begin
                    n_fail = 1'b1;
                end
            end
            default: n_crc = crc_step;
        endcase
        n_pos = (pos == POS_H_CRC) ? POS_T_MSB : pos + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_T_MSB;
            r_crc   <= CRC_INIT;
            r_fail  <= 1'b0;
            r_temp  <= '0;
            r_humid <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_fail  <= n_fail;
            r_temp  <= n_temp;
            r_humid <= n_humid;
        end
    end

    assign o_done              = i_accept && (pos == POS_H_CRC);
    assign o_frame.temp_ticks  = n_temp;
    assign o_frame.humid_ticks = n_humid;
    assign o_frame.crc_fail    = n_fail;

endmodule

// ===== hdl/hsfd_scale.sv =====
// Scaling pipeline: span multiply, divide by full scale, offset, clamp, output register.
module hsfd_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hsfd_pkg::t_frame i_frame,
    output logic             o_ready,
    hsfd_result_if.source    o_result
);
    import hsfd_pkg::*;

    logic                r_b_valid, r_c_valid;
    logic                b_en, c_en;
    logic [PROD_W-1:0]   r_prod_t, r_prod_h;
    logic                r_b_fail;
    logic [QUOT_W-1:0]   q_t, q_h, h_off;
    logic [QUOT_W-1:0]   t_val;
    logic [HUMID_W-1:0]  h_val;
    logic [TEMP_W-1:0]   r_temp;
    logic [HUMID_W-1:0]  r_humid;
    logic                r_ok;

    assign c_en    = !r_c_valid || o_result.ready;
    assign b_en    = !r_b_valid || c_en;
    assign o_ready = b_en;

    always_comb begin
        q_t   = f_div_ffff(r_prod_t);
        q_h   = f_div_ffff(r_prod_h);
        t_val = q_t - T_BASE;
        h_off = q_h - RH_BASE;
        if (q_h < RH_BASE) begin
            h_val = '0;
        end else if (h_off > RH_MAX) begin
            h_val = HUMID_W'(RH_MAX);
        end else begin
            h_val = h_off[HUMID_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (b_en) begin
                r_b_valid <= i_valid;
            end
            if (c_en) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en && i_valid) begin
            r_prod_t <= PROD_W'(T_SPAN) * PROD_W'(i_frame.temp_ticks);
            r_prod_h <= PROD_W'(RH_SPAN) * PROD_W'(i_frame.humid_ticks);
            r_b_fail <= i_frame.crc_fail;
        end
        if (c_en && r_b_valid) begin
            r_temp  <= r_b_fail ? '0 : t_val[TEMP_W-1:0];
            r_humid <= r_b_fail ? '0 : h_val;
            r_ok    <= !r_b_fail;
        end
    end

    assign o_result.valid       = r_c_valid;
    assign o_result.temp_centi  = r_temp;
    assign o_result.humid_centi = r_humid;
    assign o_result.crc_ok      = r_ok;

endmodule

// ===== hdl/humidity_sensor_frame_decoder_unit.sv =====
// Top level of the sensor reply frame decoder.
//
//   channel    dir  transfer carries
//   i_byte     in   data_byte[7:0], first_byte
//   o_result   out  temp_centi[14:0] signed, humid_centi[13:0], crc_ok
//
// One byte is taken every cycle while input ready is high; a frame's sixth
// byte yields a result via the multiply and scaling/clamp output registers.
// Synchronous active-low reset clears position, CRC and pipeline valids.
// A stalled result holds; bytes keep flowing while the two pipeline stages
// have room, so input ready depends on output ready through that chain.
module humidity_sensor_frame_decoder_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsfd_byte_if.sink     i_byte,
    hsfd_result_if.source o_result
);
    import hsfd_pkg::*;

    logic   accept;
    logic   done;
    logic   scale_ready;
    t_frame frame;

    assign i_byte.ready = scale_ready;
    assign accept       = i_byte.valid && scale_ready;

    hsfd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_byte.data_byte),
        .i_first_byte (i_byte.first_byte),
        .o_done       (done),
        .o_frame      (frame)
    );

    hsfd_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (done),
        .i_frame  (frame),
        .o_ready  (scale_ready),
        .o_result (o_result)
    );

endmodule
